// ===== rtl/framed_command_responder_crc8_macros.svh =====
// Assertion macros shared by the responder RTL.
`ifndef FRAMED_COMMAND_RESPONDER_CRC8_MACROS_SVH
`define FRAMED_COMMAND_RESPONDER_CRC8_MACROS_SVH

// Condition must never hold outside reset.
`define FCR_ASSERT_NEVER(label, clk, rst, bad) \
  label: assert property (@(posedge clk) disable iff (rst) !(bad)) \
    else $error("fcr: forbidden condition seen");

// Trigger in one cycle implies the consequence in the next.
`define FCR_ASSERT_NEXT(label, clk, rst, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("fcr: expected follow-up missing");

`endif

// ===== rtl/fcr_pkg.sv =====
// Shared constants, types and CRC function for the framed command responder.
`default_nettype none

package fcr_pkg;

  // Frame and opcode bytes
  localparam logic [7:0] DLE_CODE    = 8'd144;
  localparam logic [7:0] STX_CODE    = 8'd2;
  localparam logic [7:0] OP_READY    = 8'd77;
  localparam logic [7:0] OP_FIXED    = 8'd88;
  localparam logic [7:0] OP_SENSE    = 8'd99;
  localparam logic [7:0] READY_DATA  = 8'd1;
  localparam logic [7:0] FIXED_FIRST = 8'd12;
  localparam logic [7:0] FIXED_NEXT  = 8'd13;
  localparam logic [7:0] CRC_POLY    = 8'h07;

  // Reply data length codes
  localparam logic [1:0] LEN_NONE = 2'd0;
  localparam logic [1:0] LEN_ONE  = 2'd1;
  localparam logic [1:0] LEN_TWO  = 2'd2;

  // Command queue geometry (depth is a power of two)
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  // One classified request: data length and up to two data bytes
  typedef struct packed {
    logic [1:0] len;
    logic [7:0] d0;
    logic [7:0] d1;
  } cmd_t;

  // Request parser phase
  typedef enum logic [2:0] {
    PH_DLE = 3'b001,
    PH_STX = 3'b010,
    PH_OP  = 3'b100
  } phase_t;

  // Reply serializer step
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DLE  = 7'b0000010,
    S_STX  = 7'b0000100,
    S_LEN  = 7'b0001000,
    S_D0   = 7'b0010000,
    S_D1   = 7'b0100000,
    S_CRC  = 7'b1000000
  } step_t;

  // CRC-8, poly 0x07, MSB first, one byte
  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fcr_front.sv =====
// Request parser: finds DLE STX opcode and classifies the opcode into a command.
`default_nettype none

module fcr_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic [7:0]     rx_byte,
  input  logic [7:0]     temperature_byte,
  input  logic [7:0]     altitude_byte,
  output logic           q_push,
  output fcr_pkg::cmd_t  q_cmd,
  input  logic           q_full
);
  import fcr_pkg::*;

  phase_t phase;
  phase_t phase_next;
  logic   accept;

  // Stall input whenever the command queue has no room
  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_push = accept && (phase == PH_OP);

  // Frame phase tracking
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_DLE:  phase_next = (rx_byte == DLE_CODE) ? PH_STX : PH_DLE;
      PH_STX:  phase_next = (rx_byte == STX_CODE) ? PH_OP : PH_DLE;
      PH_OP:   phase_next = PH_DLE;
      default: phase_next = PH_DLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_DLE;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  // Opcode classification
  always_comb begin
    q_cmd.len = LEN_NONE;
    q_cmd.d0  = '0;
    q_cmd.d1  = '0;
    case (rx_byte)
      OP_READY: begin
        q_cmd.len = LEN_ONE;
        q_cmd.d0  = READY_DATA;
      end
      OP_FIXED: begin
        q_cmd.len = LEN_TWO;
        q_cmd.d0  = FIXED_FIRST;
        q_cmd.d1  = FIXED_NEXT;
      end
      OP_SENSE: begin
        q_cmd.len = LEN_TWO;
        q_cmd.d0  = temperature_byte;
        q_cmd.d1  = altitude_byte;
      end
      default: begin
        q_cmd.len = LEN_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/fcr_cmdq.sv =====
// Short command queue between the parser and the reply serializer.
`default_nettype none
`include "framed_command_responder_crc8_macros.svh"

module fcr_cmdq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fcr_pkg::cmd_t  push_cmd,
  output logic           full,
  input  logic           pop,
  output fcr_pkg::cmd_t  pop_cmd,
  output logic           valid
);
  import fcr_pkg::*;

  cmd_t                entry [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]  wr_ptr;
  logic [CMDQ_AW-1:0]  rd_ptr;
  logic [CMDQ_CW-1:0]  count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == CMDQ_CW'(CMDQ_DEPTH));
  assign valid   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign pop_cmd = entry[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `FCR_ASSERT_NEVER(a_cmdq_over, clk, rst, count > CMDQ_CW'(CMDQ_DEPTH))
  `FCR_ASSERT_NEVER(a_cmdq_push_full, clk, rst, push && full)

endmodule

`default_nettype wire

// ===== rtl/fcr_back.sv =====
// Reply serializer: walks one command into DLE STX LEN data CRC, with output register.
`default_nettype none
`include "framed_command_responder_crc8_macros.svh"

module fcr_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  fcr_pkg::cmd_t  q_cmd,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     tx_byte,
  output logic           last_byte
);
  import fcr_pkg::*;

  step_t       step;
  step_t       step_next;
  cmd_t        cmd;
  logic [7:0]  crc;
  logic        ov;
  logic [7:0]  ob;
  logic        ol;
  logic        pop_acc;
  logic        gen;
  logic        finishing;
  logic [7:0]  byte_val;
  logic        last_val;

  assign pop_acc   = pop && ov;
  assign gen       = (step != S_IDLE) && (!ov || pop_acc);
  assign finishing = gen && (step == S_CRC);
  assign q_pop     = q_valid && ((step == S_IDLE) || finishing);

  assign empty     = !ov;
  assign tx_byte   = ob;
  assign last_byte = ol;

  // Byte selection and next step
  always_comb begin
    byte_val  = '0;
    last_val  = 1'b0;
    step_next = step;
    case (step)
      S_DLE: begin
        byte_val  = DLE_CODE;
        step_next = S_STX;
      end
      S_STX: begin
        byte_val  = STX_CODE;
        step_next = S_LEN;
      end
      S_LEN: begin
        byte_val  = {6'd0, cmd.len};
        step_next = (cmd.len == LEN_NONE) ? S_CRC : S_D0;
      end
      S_D0: begin
        byte_val  = cmd.d0;
        step_next = (cmd.len == LEN_ONE) ? S_CRC : S_D1;
      end
      S_D1: begin
        byte_val  = cmd.d1;
        step_next = S_CRC;
      end
      S_CRC: begin
        byte_val  = crc;
        last_val  = 1'b1;
        step_next = S_IDLE;
      end
      default: begin
        step_next = S_IDLE;
      end
    endcase
  end

  // Sequencer: load a new command as soon as the previous one ends
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else if (q_pop) begin
      step <= S_DLE;
    end else if (gen) begin
      step <= step_next;
    end
  end

  // Command hold and running CRC over data bytes
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_cmd;
      crc <= '0;
    end else if (gen && ((step == S_D0) || (step == S_D1))) begin
      crc <= crc8_update(crc, byte_val);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (gen) begin
      ov <= 1'b1;
    end else if (pop_acc) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (gen) begin
      ob <= byte_val;
      ol <= last_val;
    end
  end

  `FCR_ASSERT_NEVER(a_back_pop_empty, clk, rst, q_pop && !q_valid)
  `FCR_ASSERT_NEXT(a_back_crc_last, clk, rst, finishing, ov && ol)

endmodule

`default_nettype wire

// ===== rtl/framed_command_responder_crc8.sv =====
// The first reply byte (DLE) goes via queue entry, step register and output register to tx_byte.
// Throughput: one received item per cycle while the two-entry command queue has room;
// reply bytes leave one per cycle while pop is held; replies run back to back, 4 to 6 bytes each.
// Output rate is set by the single reply serializer; input stalls only when the queue fills.
// Reset (rst, synchronous): parser waits for DLE, command queue and output register are emptied.
`default_nettype none

module framed_command_responder_crc8 (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  input  logic [7:0] temperature_byte,
  input  logic [7:0] altitude_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] tx_byte,
  output logic       last_byte
);
  import fcr_pkg::*;

  logic  fq_push;
  cmd_t  fq_cmd;
  logic  fq_full;
  logic  qb_pop;
  cmd_t  qb_cmd;
  logic  qb_valid;

  // Front: parse and classify
  fcr_front u_front (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .rx_byte          (rx_byte),
    .temperature_byte (temperature_byte),
    .altitude_byte    (altitude_byte),
    .q_push           (fq_push),
    .q_cmd            (fq_cmd),
    .q_full           (fq_full)
  );

  // Decoupling command queue
  fcr_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (fq_push),
    .push_cmd (fq_cmd),
    .full     (fq_full),
    .pop      (qb_pop),
    .pop_cmd  (qb_cmd),
    .valid    (qb_valid)
  );

  // Back: reply framing and CRC
  fcr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (qb_valid),
    .q_cmd     (qb_cmd),
    .q_pop     (qb_pop),
    .empty     (empty),
    .pop       (pop),
    .tx_byte   (tx_byte),
    .last_byte (last_byte)
  );

endmodule

`default_nettype wire

// ===== bench/tb_framed_command_responder_crc8.sv =====
// Self-checking testbench for the framed command responder with CRC-8 replies.
`timescale 1ns / 1ps

module tb_framed_command_responder_crc8;
  import fcr_pkg::*;

  // One received byte with the sensor readings present at that time
  typedef struct {
    logic [7:0] rx;
    logic [7:0] temp;
    logic [7:0] alt;
  } rx_item_t;

  // One reply byte as it should leave the block
  typedef struct {
    logic [7:0] data;
    logic       fin;
  } reply_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic [7:0] rx_byte = 8'd0;
  logic [7:0] temperature_byte = 8'd0;
  logic [7:0] altitude_byte = 8'd0;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] tx_byte;
  logic       last_byte;

  rx_item_t    rx_backlog[$];
  reply_byte_t reply_bytes_due[$];
  phase_t      parse_phase = PH_DLE;
  int          bad_count = 0;
  int          sent_count = 0;
  int          send_gap = 0;
  int          pop_stall = 0;
  int          cycle_count = 0;
  rx_item_t    next_rx;
  reply_byte_t want;

  framed_command_responder_crc8 uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .rx_byte(rx_byte),
    .temperature_byte(temperature_byte),
    .altitude_byte(altitude_byte),
    .empty(empty),
    .pop(pop),
    .tx_byte(tx_byte),
    .last_byte(last_byte)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // CRC-8, poly 0x07, one bit at a time from the MSB
  function automatic logic [7:0] crc_next(logic [7:0] crc, logic [7:0] d);
    logic fb;
    for (int b = 7; b >= 0; b--) begin
      fb = crc[7] ^ d[b];
      crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return crc;
  endfunction

  function automatic void queue_reply_byte(logic [7:0] d, logic fin);
    reply_byte_t r;
    r.data = d;
    r.fin = fin;
    reply_bytes_due.push_back(r);
  endfunction

  // Request parser; queues the reply frame when an opcode completes a request
  function automatic void frame_response(rx_item_t it);
    logic [7:0] payload[2];
    logic [7:0] crc;
    int         len;
    crc = 8'h00;
    len = 0;
    if (parse_phase == PH_STX) begin
      parse_phase = (it.rx == STX_CODE) ? PH_OP : PH_DLE;
    end else if (parse_phase != PH_OP) begin
      parse_phase = (it.rx == DLE_CODE) ? PH_STX : PH_DLE;
    end else begin
      parse_phase = PH_DLE;
      case (it.rx)
        OP_READY: begin
          payload[0] = READY_DATA;
          len = 1;
        end
        OP_FIXED: begin
          payload[0] = FIXED_FIRST;
          payload[1] = FIXED_NEXT;
          len = 2;
        end
        OP_SENSE: begin
          payload[0] = it.temp;
          payload[1] = it.alt;
          len = 2;
        end
        default: len = 0;
      endcase
      queue_reply_byte(DLE_CODE, 1'b0);
      queue_reply_byte(STX_CODE, 1'b0);
      queue_reply_byte(8'(len), 1'b0);
      for (int i = 0; i < len; i++) begin
        queue_reply_byte(payload[i], 1'b0);
        crc = crc_next(crc, payload[i]);
      end
      queue_reply_byte(crc, 1'b1);
    end
  endfunction

  // Mostly short idles, a few long ones
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  task automatic add_byte(logic [7:0] rx);
    rx_item_t it;
    it.rx = rx;
    it.temp = 8'($urandom);
    it.alt = 8'($urandom);
    rx_backlog.push_back(it);
  endtask

  // Full request: DLE, STX, opcode carrying the given readings
  task automatic add_request(logic [7:0] op, logic [7:0] temp, logic [7:0] alt);
    rx_item_t it;
    add_byte(DLE_CODE);
    add_byte(STX_CODE);
    it.rx = op;
    it.temp = temp;
    it.alt = alt;
    rx_backlog.push_back(it);
  endtask

  // Sender: offers backlog items, holds while full, idles at random
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      send_gap = 0;
    end else begin
      if (push && !full) begin
        next_rx.rx = rx_byte;
        next_rx.temp = temperature_byte;
        next_rx.alt = altitude_byte;
        frame_response(next_rx);
        sent_count++;
      end
      if (push && full) begin
        // hold the item until it is taken
      end else if (send_gap > 0) begin
        push <= 1'b0;
        send_gap--;
      end else if (rx_backlog.size() > 0) begin
        next_rx = rx_backlog.pop_front();
        push <= 1'b1;
        rx_byte <= next_rx.rx;
        temperature_byte <= next_rx.temp;
        altitude_byte <= next_rx.alt;
        // a stretch of back-to-back items in the middle of the run
        if ((sent_count < 60 || sent_count >= 90) && $urandom_range(0, 1) == 1)
          send_gap = idle_length();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: checks each popped reply byte, stalls at random
  always @(posedge clk) begin
    cycle_count++;
    if (rst) begin
      pop <= 1'b0;
      pop_stall = 0;
    end else begin
      if (pop && !empty) begin
        if (reply_bytes_due.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t: unexpected reply byte tx_byte=%0d last_byte=%0b",
                     $realtime, tx_byte, last_byte);
        end else begin
          want = reply_bytes_due.pop_front();
          if (tx_byte !== want.data || last_byte !== want.fin) begin
            bad_count++;
            if (bad_count <= 10)
              $display("%0t: reply mismatch: tx_byte exp %0d got %0d, last_byte exp %0b got %0b",
                       $realtime, want.data, tx_byte, want.fin, last_byte);
          end
        end
      end
      if (pop_stall > 0) begin
        pop <= 1'b0;
        pop_stall--;
      end else begin
        pop <= 1'b1;
        // in one window out of four (cycle_count[11:10] == 1) no new stalls start
        if (cycle_count[11:10] != 2'd1 && $urandom_range(0, 99) < 20)
          pop_stall = idle_length();
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    // directed: stray STX, each opcode, reading extremes
    add_byte(STX_CODE);
    add_request(OP_READY, 8'd0, 8'd0);
    add_request(OP_FIXED, 8'd255, 8'd255);
    add_request(OP_SENSE, 8'd255, 8'd0);
    add_request(OP_SENSE, 8'd0, 8'd255);
    // byte after DLE is not STX: dropped
    add_byte(DLE_CODE);
    add_byte(8'd0);
    // DLE after DLE is dropped too, so the STX is just noise
    add_byte(DLE_CODE);
    add_byte(DLE_CODE);
    add_byte(STX_CODE);
    // unknown opcodes at both ends of the byte range
    add_request(8'd0, 8'($urandom), 8'($urandom));
    add_request(8'd255, 8'($urandom), 8'($urandom));

    // random: mostly well-formed requests, some noise and broken requests
    while (rx_backlog.size() < 120) begin
      case ($urandom_range(0, 9))
        7: add_byte(8'($urandom));
        8: begin
          add_byte(DLE_CODE);
          add_byte(8'($urandom));
        end
        9: begin
          add_byte(DLE_CODE);
          add_byte(DLE_CODE);
          add_byte(STX_CODE);
        end
        default: begin
          case ($urandom_range(0, 4))
            0: add_request(OP_READY, 8'($urandom), 8'($urandom));
            1: add_request(OP_FIXED, 8'($urandom), 8'($urandom));
            2, 3: add_request(OP_SENSE, 8'($urandom), 8'($urandom));
            default: add_request(8'($urandom), 8'($urandom), 8'($urandom));
          endcase
        end
      endcase
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk); while (rx_backlog.size() != 0 || push);
    while (reply_bytes_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (reply_bytes_due.size() != 0) bad_count++;

    if (bad_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/fcr_pkg.sv
rtl/fcr_front.sv
rtl/fcr_cmdq.sv
rtl/fcr_back.sv
rtl/framed_command_responder_crc8.sv
bench/tb_framed_command_responder_crc8.sv
